// ===== design/pbcr_pkg.sv =====
// ============================================================================
// pbcr_pkg
// Shared sizes and codes for the page buffer clock replacement unit.
// ============================================================================
`default_nettype none

package pbcr_pkg;

    // slot pool geometry
    localparam int NUM_SLOTS = 16;
    localparam int SLOT_W    = $clog2(NUM_SLOTS);
    localparam int CNT_W     = SLOT_W + 1;
    localparam int MIN_SLOTS = 2;

    // usage counter
    localparam int USAGE_MAX = 10;
    localparam int USAGE_W   = 4;

    // tags and config
    localparam int TAG_W          = 32;
    localparam int ACTIVE_W       = 5;
    localparam int ACTIVE_RESET   = 16;

    // operation codes
    localparam logic OP_REQUEST = 1'b0;
    localparam logic OP_RELEASE = 1'b1;

    // result status codes
    localparam logic [1:0] STATUS_OK         = 2'd0;
    localparam logic [1:0] STATUS_ALL_PINNED = 2'd1;
    localparam logic [1:0] STATUS_NOT_FOUND  = 2'd2;

endpackage

`default_nettype wire

// ===== design/page_buffer_clock_replacement_unit.sv =====
// ============================================================================
// page_buffer_clock_replacement_unit
// Buffer-pool slot manager: tag lookup, pin/release, clock sweep victim pick.
// ============================================================================
// Flow: an accepted beat scans slots until a tag hit, comparing at most the live
//   count n; a request that misses with an unpinned slot then runs the clock
//   sweep. The result posts once the output register is free; output stalls
//   hold the post. One beat at a time; the next beat is taken once the unit is
//   back in idle. Scan and sweep visit one slot per cycle through one unit.
// Reset: valid, pin and usage flags, clock hand and handshakes clear at once;
//   active_slots returns to 16. Tag storage is not cleared.
`default_nettype none

module page_buffer_clock_replacement_unit (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    // configuration
    input  wire logic                              active_slots_we,
    input  wire logic [pbcr_pkg::ACTIVE_W-1:0]     active_slots,
    // input channel
    input  wire logic                              in_valid,
    output logic                                   in_stall,
    input  wire logic                              operation,
    input  wire logic [pbcr_pkg::TAG_W-1:0]        table_id,
    input  wire logic [pbcr_pkg::TAG_W-1:0]        page_number,
    // output channel
    output logic                                   out_valid,
    input  wire logic                              out_stall,
    output logic [pbcr_pkg::SLOT_W-1:0]            slot_index,
    output logic                                   load_needed,
    output logic [1:0]                             status
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_SWEEP,
        S_FINISH
    } state_t;

    state_t state_reg;

    // config
    logic [pbcr_pkg::ACTIVE_W-1:0] active_reg;

    // per-slot flags
    logic [pbcr_pkg::NUM_SLOTS-1:0]  valid_reg;
    logic [pbcr_pkg::NUM_SLOTS-1:0]  pinned_reg;
    logic [pbcr_pkg::USAGE_W-1:0]    usage_reg [pbcr_pkg::NUM_SLOTS];
    logic [pbcr_pkg::SLOT_W-1:0]     hand_reg;

    // tag storage
    logic [pbcr_pkg::TAG_W-1:0] tbl_mem  [pbcr_pkg::NUM_SLOTS];
    logic [pbcr_pkg::TAG_W-1:0] page_mem [pbcr_pkg::NUM_SLOTS];
    logic [pbcr_pkg::TAG_W-1:0] tbl_rd_reg;
    logic [pbcr_pkg::TAG_W-1:0] page_rd_reg;
    logic [pbcr_pkg::SLOT_W-1:0] rd_addr;
    logic                        tag_we;

    // current beat
    logic                          op_reg;
    logic [pbcr_pkg::TAG_W-1:0]    tbl_reg;
    logic [pbcr_pkg::TAG_W-1:0]    page_reg;
    logic [pbcr_pkg::CNT_W-1:0]    n_reg;
    logic [pbcr_pkg::SLOT_W-1:0]   cmp_idx_reg;
    logic                          free_seen_reg;

    // pending result
    logic [pbcr_pkg::SLOT_W-1:0]   res_slot_reg;
    logic                          res_load_reg;
    logic [1:0]                    res_status_reg;

    // output register
    logic                          out_valid_reg;
    logic [pbcr_pkg::SLOT_W-1:0]   out_slot_reg;
    logic                          out_load_reg;
    logic [1:0]                    out_status_reg;

    logic                          in_accept;
    logic [pbcr_pkg::CNT_W-1:0]    live_n;
    logic                          tag_match;
    logic                          scan_last;
    logic                          free_all;
    logic [pbcr_pkg::SLOT_W-1:0]   hand_start;
    logic [pbcr_pkg::SLOT_W-1:0]   hand_adv;
    logic                          victim;
    logic [pbcr_pkg::USAGE_W-1:0]  hit_usage;

    assign in_stall  = (state_reg != S_IDLE);
    assign in_accept = in_valid && !in_stall;

    assign out_valid   = out_valid_reg;
    assign slot_index  = out_slot_reg;
    assign load_needed = out_load_reg;
    assign status      = out_status_reg;

    // live slot count, clamped to the pool
    always_comb
    begin
        if (active_reg < pbcr_pkg::ACTIVE_W'(pbcr_pkg::MIN_SLOTS))
            live_n = pbcr_pkg::CNT_W'(pbcr_pkg::MIN_SLOTS);
        else if (active_reg > pbcr_pkg::ACTIVE_W'(pbcr_pkg::NUM_SLOTS))
            live_n = pbcr_pkg::CNT_W'(pbcr_pkg::NUM_SLOTS);
        else
            live_n = pbcr_pkg::CNT_W'(active_reg);
    end

    // scan compare on the slot whose tags were read last cycle
    assign tag_match = valid_reg[cmp_idx_reg] && (tbl_rd_reg == tbl_reg)
                       && (page_rd_reg == page_reg);
    assign scan_last = ({1'b0, cmp_idx_reg} == (n_reg - pbcr_pkg::CNT_W'(1)));
    assign free_all  = free_seen_reg || !pinned_reg[cmp_idx_reg];

    // scan reads slot 0 on accept, then one slot ahead of the compare
    assign rd_addr = in_accept ? '0 : (cmp_idx_reg + pbcr_pkg::SLOT_W'(1));

    // clock hand helpers
    assign hand_start = ({1'b0, hand_reg} < n_reg) ? hand_reg : '0;
    assign hand_adv   = (({1'b0, hand_reg} + pbcr_pkg::CNT_W'(1)) < n_reg)
                        ? (hand_reg + pbcr_pkg::SLOT_W'(1)) : '0;
    assign victim     = !pinned_reg[hand_reg] && (usage_reg[hand_reg] == '0);

    // saturating usage bump on a hit
    assign hit_usage = (usage_reg[cmp_idx_reg] < pbcr_pkg::USAGE_W'(pbcr_pkg::USAGE_MAX))
                       ? (usage_reg[cmp_idx_reg] + pbcr_pkg::USAGE_W'(1))
                       : usage_reg[cmp_idx_reg];

    assign tag_we = (state_reg == S_SWEEP) && victim;

    // tag memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (tag_we)
        begin
            tbl_mem[hand_reg]  <= tbl_reg;
            page_mem[hand_reg] <= page_reg;
        end
        tbl_rd_reg  <= tbl_mem[rd_addr];
        page_rd_reg <= page_mem[rd_addr];
    end

    // beat payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            op_reg   <= operation;
            tbl_reg  <= table_id;
            page_reg <= page_number;
        end
    end

    // sequencer, slot flags and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            active_reg     <= pbcr_pkg::ACTIVE_W'(pbcr_pkg::ACTIVE_RESET);
            valid_reg      <= '0;
            pinned_reg     <= '0;
            for (int i = 0; i < pbcr_pkg::NUM_SLOTS; i++)
                usage_reg[i] <= '0;
            hand_reg       <= '0;
            n_reg          <= '0;
            cmp_idx_reg    <= '0;
            free_seen_reg  <= 1'b0;
            res_slot_reg   <= '0;
            res_load_reg   <= 1'b0;
            res_status_reg <= pbcr_pkg::STATUS_OK;
            out_valid_reg  <= 1'b0;
            out_slot_reg   <= '0;
            out_load_reg   <= 1'b0;
            out_status_reg <= pbcr_pkg::STATUS_OK;
        end
        else
        begin
            if (active_slots_we)
                active_reg <= active_slots;

            // result taken downstream; the finish state reloads it itself
            if (out_valid_reg && !out_stall && (state_reg != S_FINISH))
                out_valid_reg <= 1'b0;

            case (state_reg)
                S_IDLE:
                begin
                    if (in_accept)
                    begin
                        n_reg         <= live_n;
                        cmp_idx_reg   <= '0;
                        free_seen_reg <= 1'b0;
                        state_reg     <= S_SCAN;
                    end
                end

                // tag lookup, one slot per cycle
                S_SCAN:
                begin
                    free_seen_reg <= free_all;
                    if (tag_match)
                    begin
                        res_slot_reg   <= cmp_idx_reg;
                        res_load_reg   <= 1'b0;
                        res_status_reg <= pbcr_pkg::STATUS_OK;
                        if (op_reg == pbcr_pkg::OP_RELEASE)
                            pinned_reg[cmp_idx_reg] <= 1'b0;
                        else
                        begin
                            pinned_reg[cmp_idx_reg] <= 1'b1;
                            usage_reg[cmp_idx_reg]  <= hit_usage;
                        end
                        state_reg <= S_FINISH;
                    end
                    else if (scan_last)
                    begin
                        res_slot_reg <= '0;
                        res_load_reg <= 1'b0;
                        if (op_reg == pbcr_pkg::OP_RELEASE)
                        begin
                            res_status_reg <= pbcr_pkg::STATUS_NOT_FOUND;
                            state_reg      <= S_FINISH;
                        end
                        else if (!free_all)
                        begin
                            res_status_reg <= pbcr_pkg::STATUS_ALL_PINNED;
                            state_reg      <= S_FINISH;
                        end
                        else
                        begin
                            hand_reg  <= hand_start;
                            state_reg <= S_SWEEP;
                        end
                    end
                    else
                        cmp_idx_reg <= cmp_idx_reg + pbcr_pkg::SLOT_W'(1);
                end

                // clock sweep, one slot per cycle
                S_SWEEP:
                begin
                    hand_reg <= hand_adv;
                    if (victim)
                    begin
                        valid_reg[hand_reg]  <= 1'b1;
                        pinned_reg[hand_reg] <= 1'b1;
                        usage_reg[hand_reg]  <= pbcr_pkg::USAGE_W'(1);
                        res_slot_reg   <= hand_reg;
                        res_load_reg   <= 1'b1;
                        res_status_reg <= pbcr_pkg::STATUS_OK;
                        state_reg      <= S_FINISH;
                    end
                    else if (usage_reg[hand_reg] != '0)
                        usage_reg[hand_reg] <= usage_reg[hand_reg] - pbcr_pkg::USAGE_W'(1);
                end

                // post result once the output register is free
                S_FINISH:
                begin
                    if (!out_valid_reg || !out_stall)
                    begin
                        out_valid_reg  <= 1'b1;
                        out_slot_reg   <= res_slot_reg;
                        out_load_reg   <= res_load_reg;
                        out_status_reg <= res_status_reg;
                        state_reg      <= S_IDLE;
                    end
                end

                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------------
    a_accept_starts_scan: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> (state_reg == S_SCAN))
        else $error("accepted beat did not start a scan");

    a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> ({1'b0, cmp_idx_reg} < n_reg))
        else $error("scan index beyond live slot count");

    a_victim_claimed: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_SWEEP) && victim) |=>
            (pinned_reg[res_slot_reg] && valid_reg[res_slot_reg]
             && (usage_reg[res_slot_reg] == pbcr_pkg::USAGE_W'(1))))
        else $error("victim slot not claimed after sweep");

    a_load_only_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_load_reg) |-> (out_status_reg == pbcr_pkg::STATUS_OK))
        else $error("load flagged on a failed beat");

    a_usage_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |->
            (usage_reg[cmp_idx_reg] <= pbcr_pkg::USAGE_W'(pbcr_pkg::USAGE_MAX)))
        else $error("usage count above limit");

endmodule

`default_nettype wire

// ===== tb/sv/page_buffer_clock_replacement_unit_tb.sv =====
// ============================================================================
// page_buffer_clock_replacement_unit_tb
// Self-checking bench for the buffer-pool slot manager. A shadow copy of the
// slot table predicts every result: tag hit, clock-sweep victim, all-pinned,
// and absent release. Directed beats come first, then random phases across
// several pool sizes, with random input gaps and random output back-pressure.
// ============================================================================
`default_nettype none

module page_buffer_clock_replacement_unit_tb;

    localparam int POOL_SIZE      = 24;
    localparam int TABLE_IDS      = 4;
    localparam int PHASE_BEATS    = 80;
    localparam int SETTLE_CYCLES  = 4;
    localparam int END_WAIT       = 40;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int MAX_REPORTS    = 10;

    typedef enum logic [1:0] {
        ITEM_BEAT,
        ITEM_CONFIG,
        ITEM_DRAIN
    } item_kind_t;

    typedef struct packed {
        item_kind_t                    kind;
        logic                          op;
        logic [pbcr_pkg::TAG_W-1:0]    tbl;
        logic [pbcr_pkg::TAG_W-1:0]    pg;
        logic [pbcr_pkg::ACTIVE_W-1:0] setting;
    } pending_op_t;

    typedef struct packed {
        logic [pbcr_pkg::SLOT_W-1:0] slot;
        logic                        load;
        logic [1:0]                  status;
    } slot_result_t;

    // DUT signals; the inputs are known from time zero
    logic                          clk             = 1'b0;
    logic                          rst_n           = 1'b0;
    logic                          active_slots_we = 1'b0;
    logic [pbcr_pkg::ACTIVE_W-1:0] active_slots    = '0;
    logic                          in_valid        = 1'b0;
    logic                          in_stall;
    logic                          operation       = pbcr_pkg::OP_REQUEST;
    logic [pbcr_pkg::TAG_W-1:0]    table_id        = '0;
    logic [pbcr_pkg::TAG_W-1:0]    page_number     = '0;
    logic                          out_valid;
    logic                          out_stall       = 1'b0;
    logic [pbcr_pkg::SLOT_W-1:0]   slot_index;
    logic                          load_needed;
    logic [1:0]                    status;

    // handshake flags seen by the falling-edge drivers
    logic beat_taken   = 1'b0;
    logic result_taken = 1'b0;

    pending_op_t  pending_ops[$];
    slot_result_t expected_slots[$];
    int           fail_count = 0;

    // shadow slot table
    logic                          shadow_valid [pbcr_pkg::NUM_SLOTS];
    logic [pbcr_pkg::TAG_W-1:0]    shadow_table [pbcr_pkg::NUM_SLOTS];
    logic [pbcr_pkg::TAG_W-1:0]    shadow_page  [pbcr_pkg::NUM_SLOTS];
    logic                          shadow_pin   [pbcr_pkg::NUM_SLOTS];
    logic [pbcr_pkg::USAGE_W-1:0]  shadow_count [pbcr_pkg::NUM_SLOTS];
    int                            shadow_hand;
    logic [pbcr_pkg::ACTIVE_W-1:0] shadow_active;

    // stimulus pool, small so that hits are common
    logic [pbcr_pkg::TAG_W-1:0] pool_table [POOL_SIZE];
    logic [pbcr_pkg::TAG_W-1:0] pool_page  [POOL_SIZE];
    logic [pbcr_pkg::TAG_W-1:0] table_ids  [TABLE_IDS];

    // driver-side counters
    int hold_off     = 0;
    int quiet_cycles = 0;
    int beats_sent   = 0;
    bit send_calm    = 1'b0;
    int stall_left   = 0;
    int results_seen = 0;
    bit recv_calm    = 1'b0;
    int stuck_cycles = 0;

    page_buffer_clock_replacement_unit i_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .active_slots_we (active_slots_we),
        .active_slots    (active_slots),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .operation       (operation),
        .table_id        (table_id),
        .page_number     (page_number),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .slot_index      (slot_index),
        .load_needed     (load_needed),
        .status          (status)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Shadow model: lookup, pin/release, clock sweep
    // ------------------------------------------------------------------------
    function automatic slot_result_t predict_slot(logic op,
                                                  logic [pbcr_pkg::TAG_W-1:0] tbl,
                                                  logic [pbcr_pkg::TAG_W-1:0] pg);
        slot_result_t r;
        int           n;
        int           hit;
        int           h;
        int           i;
        int           victim;
        bit           any_free;
        bit           found;
        r.slot   = '0;
        r.load   = 1'b0;
        r.status = pbcr_pkg::STATUS_OK;
        n = shadow_active;
        if (n < pbcr_pkg::MIN_SLOTS)
            n = pbcr_pkg::MIN_SLOTS;
        if (n > pbcr_pkg::NUM_SLOTS)
            n = pbcr_pkg::NUM_SLOTS;

        // lowest matching valid slot wins
        hit = -1;
        for (i = n - 1; i >= 0; i--)
            if (shadow_valid[i] && shadow_table[i] == tbl && shadow_page[i] == pg)
                hit = i;

        if (op == pbcr_pkg::OP_RELEASE)
        begin
            if (hit < 0)
                r.status = pbcr_pkg::STATUS_NOT_FOUND;
            else
            begin
                r.slot          = pbcr_pkg::SLOT_W'(hit);
                shadow_pin[hit] = 1'b0;
            end
        end
        else if (hit >= 0)
        begin
            r.slot = pbcr_pkg::SLOT_W'(hit);
            if (shadow_count[hit] < pbcr_pkg::USAGE_MAX)
                shadow_count[hit] = shadow_count[hit] + 1'b1;
            shadow_pin[hit] = 1'b1;
        end
        else
        begin
            any_free = 1'b0;
            for (i = 0; i < n; i++)
                if (!shadow_pin[i])
                    any_free = 1'b1;
            if (!any_free)
                r.status = pbcr_pkg::STATUS_ALL_PINNED;
            else
            begin
                // sweep: decrement used slots, stop on unpinned zero count
                h      = (shadow_hand < n) ? shadow_hand : 0;
                found  = 1'b0;
                victim = 0;
                for (i = 0; i < n * 17 && !found; i++)
                begin
                    if (!shadow_pin[h] && shadow_count[h] == 0)
                    begin
                        victim = h;
                        found  = 1'b1;
                    end
                    else if (shadow_count[h] > 0)
                        shadow_count[h] = shadow_count[h] - 1'b1;
                    h = (h + 1 < n) ? h + 1 : 0;
                end
                shadow_hand          = h;
                shadow_valid[victim] = 1'b1;
                shadow_table[victim] = tbl;
                shadow_page[victim]  = pg;
                shadow_pin[victim]   = 1'b1;
                shadow_count[victim] = pbcr_pkg::USAGE_W'(1);
                r.slot = pbcr_pkg::SLOT_W'(victim);
                r.load = 1'b1;
            end
        end
        return r;
    endfunction

    task automatic report_error(string msg);
        fail_count++;
        if (fail_count <= MAX_REPORTS)
            $display("ERROR: %s", msg);
    endtask

    // ------------------------------------------------------------------------
    // Stimulus building
    // ------------------------------------------------------------------------
    task automatic queue_beat(logic op, logic [pbcr_pkg::TAG_W-1:0] tbl,
                              logic [pbcr_pkg::TAG_W-1:0] pg);
        pending_op_t p;
        p.kind    = ITEM_BEAT;
        p.op      = op;
        p.tbl     = tbl;
        p.pg      = pg;
        p.setting = '0;
        pending_ops.push_back(p);
    endtask

    task automatic queue_setting(logic [pbcr_pkg::ACTIVE_W-1:0] setting);
        pending_op_t p;
        p         = '0;
        p.kind    = ITEM_CONFIG;
        p.setting = setting;
        pending_ops.push_back(p);
    endtask

    task automatic queue_drain();
        pending_op_t p;
        p      = '0;
        p.kind = ITEM_DRAIN;
        pending_ops.push_back(p);
    endtask

    // replace one table id and about half the pool entries
    task automatic refresh_pool();
        int k;
        table_ids[$urandom_range(0, TABLE_IDS - 1)] = $urandom();
        for (k = 0; k < POOL_SIZE; k++)
            if ($urandom_range(0, 1) == 0)
            begin
                pool_table[k] = table_ids[$urandom_range(0, TABLE_IDS - 1)];
                pool_page[k]  = $urandom();
            end
    endtask

    // mostly request/release traffic on pool pages, some random noise
    task automatic queue_random_run(int count);
        int k;
        int sel;
        int idx;
        for (k = 0; k < count; k++)
        begin
            sel = $urandom_range(0, 99);
            idx = $urandom_range(0, POOL_SIZE - 1);
            if (sel < 55)
                queue_beat(pbcr_pkg::OP_REQUEST, pool_table[idx], pool_page[idx]);
            else if (sel < 88)
                queue_beat(pbcr_pkg::OP_RELEASE, pool_table[idx], pool_page[idx]);
            else
                queue_beat(1'($urandom_range(0, 1)), $urandom(), $urandom());
        end
    endtask

    // ------------------------------------------------------------------------
    // Input driver: beats, register writes and drain pauses
    // ------------------------------------------------------------------------
    always @(negedge clk)
    begin : drive_inputs
        logic        next_valid;
        logic        next_we;
        pending_op_t item;
        next_valid = in_valid && !beat_taken;
        next_we    = 1'b0;
        if (!next_valid && expected_slots.size() == 0)
            quiet_cycles++;
        else
            quiet_cycles = 0;

        if (rst_n && !next_valid)
        begin
            if (hold_off > 0)
                hold_off--;
            else if (pending_ops.size() > 0)
            begin
                case (pending_ops[0].kind)
                    ITEM_BEAT:
                    begin
                        item = pending_ops.pop_front();
                        operation   <= item.op;
                        table_id    <= item.tbl;
                        page_number <= item.pg;
                        next_valid  = 1'b1;
                        beats_sent++;
                        if (beats_sent % 50 == 0)
                            send_calm = ($urandom_range(0, 2) == 0);
                        hold_off = send_calm ? 0 : $urandom_range(0, 12);
                    end
                    ITEM_CONFIG:
                    begin
                        if (quiet_cycles >= SETTLE_CYCLES)
                        begin
                            item = pending_ops.pop_front();
                            active_slots <= item.setting;
                            next_we  = 1'b1;
                            hold_off = 2;
                        end
                    end
                    default:
                    begin
                        if (quiet_cycles >= SETTLE_CYCLES)
                        begin
                            item     = pending_ops.pop_front();
                            hold_off = $urandom_range(0, 12);
                        end
                    end
                endcase
            end
        end
        in_valid        <= next_valid;
        active_slots_we <= next_we;
    end

    // ------------------------------------------------------------------------
    // Output back-pressure: one random stall run per result beat
    // ------------------------------------------------------------------------
    always @(negedge clk)
    begin : drive_stall
        if (result_taken)
        begin
            results_seen++;
            if (results_seen % 40 == 0)
                recv_calm = ($urandom_range(0, 2) == 0);
            stall_left = recv_calm ? 0 : $urandom_range(0, 12);
        end
        if (stall_left > 0)
        begin
            stall_left--;
            out_stall <= 1'b1;
        end
        else
            out_stall <= 1'b0;
    end

    // ------------------------------------------------------------------------
    // Monitor: predict on input beats, check output beats, watchdog
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin : monitor
        slot_result_t got;
        slot_result_t want;
        beat_taken   <= rst_n && in_valid && !in_stall;
        result_taken <= rst_n && out_valid && !out_stall;
        if (rst_n)
        begin
            if (active_slots_we)
                shadow_active = active_slots;

            if (out_valid && !out_stall)
            begin
                got.slot   = slot_index;
                got.load   = load_needed;
                got.status = status;
                if (expected_slots.size() == 0)
                    report_error($sformatf("unexpected result slot=%0d load=%0b status=%0d",
                                           got.slot, got.load, got.status));
                else
                begin
                    want = expected_slots.pop_front();
                    if (got !== want)
                        report_error($sformatf(
                            "slot exp %0d got %0d, load exp %0b got %0b, status exp %0d got %0d",
                            want.slot, got.slot, want.load, got.load,
                            want.status, got.status));
                end
            end

            if (in_valid && !in_stall)
                expected_slots.push_back(predict_slot(operation, table_id, page_number));

            if ((in_valid && !in_stall) || (out_valid && !out_stall) || active_slots_we)
                stuck_cycles = 0;
            else
                stuck_cycles++;
            if (stuck_cycles >= WATCHDOG_LIMIT)
            begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial
    begin : run_test
        int i;
        logic [pbcr_pkg::ACTIVE_W-1:0] settings [10];
        settings = '{5'd16, 5'd2, 5'd31, 5'd5, 5'd0, 5'd9, 5'd17, 5'd3, 5'd1, 5'd16};

        for (i = 0; i < pbcr_pkg::NUM_SLOTS; i++)
        begin
            shadow_valid[i] = 1'b0;
            shadow_table[i] = '0;
            shadow_page[i]  = '0;
            shadow_pin[i]   = 1'b0;
            shadow_count[i] = '0;
        end
        shadow_hand   = 0;
        shadow_active = pbcr_pkg::ACTIVE_W'(pbcr_pkg::ACTIVE_RESET);

        // directed: extreme tags, hit, same table other page, releases
        queue_beat(pbcr_pkg::OP_REQUEST, 32'h0000_0000, 32'h0000_0000);
        queue_beat(pbcr_pkg::OP_REQUEST, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        queue_beat(pbcr_pkg::OP_REQUEST, 32'h0000_0000, 32'h0000_0000);
        queue_beat(pbcr_pkg::OP_REQUEST, 32'h0000_0000, 32'hFFFF_FFFF);
        queue_beat(pbcr_pkg::OP_RELEASE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        queue_beat(pbcr_pkg::OP_RELEASE, 32'h1234_5678, 32'h0000_0000);
        queue_beat(pbcr_pkg::OP_RELEASE, 32'h0000_0000, 32'h0000_0000);
        // below minimum: two slots, hand now past the end
        queue_setting(5'd1);
        queue_beat(pbcr_pkg::OP_REQUEST, 32'h0000_0000, 32'h0000_0000);
        queue_beat(pbcr_pkg::OP_REQUEST, 32'hA5A5_A5A5, 32'h5A5A_5A5A);
        queue_beat(pbcr_pkg::OP_REQUEST, 32'hC3C3_C3C3, 32'h3C3C_3C3C);
        queue_beat(pbcr_pkg::OP_RELEASE, 32'hA5A5_A5A5, 32'h5A5A_5A5A);
        queue_beat(pbcr_pkg::OP_REQUEST, 32'hC3C3_C3C3, 32'h3C3C_3C3C);
        queue_beat(pbcr_pkg::OP_RELEASE, 32'hC3C3_C3C3, 32'h3C3C_3C3C);
        queue_beat(pbcr_pkg::OP_RELEASE, 32'h0000_0000, 32'h0000_0000);
        // above maximum: inactive slots come back with their old tags
        queue_setting(5'd31);
        queue_beat(pbcr_pkg::OP_REQUEST, 32'h0000_0000, 32'hFFFF_FFFF);
        queue_beat(pbcr_pkg::OP_RELEASE, 32'h0000_0000, 32'hFFFF_FFFF);
        queue_setting(5'd0);
        queue_beat(pbcr_pkg::OP_REQUEST, 32'hAAAA_AAAA, 32'h5555_5555);
        queue_beat(pbcr_pkg::OP_REQUEST, 32'h5555_5555, 32'hAAAA_AAAA);
        queue_setting(5'd17);
        queue_beat(pbcr_pkg::OP_REQUEST, 32'h5555_5555, 32'hAAAA_AAAA);

        // random phases over several pool sizes
        for (i = 0; i < TABLE_IDS; i++)
            table_ids[i] = $urandom();
        for (i = 0; i < POOL_SIZE; i++)
        begin
            pool_table[i] = table_ids[$urandom_range(0, TABLE_IDS - 1)];
            pool_page[i]  = $urandom();
        end
        for (i = 0; i < 10; i++)
        begin
            queue_setting(settings[i]);
            refresh_pool();
            if (i == 3)
            begin
                queue_random_run(PHASE_BEATS / 2);
                queue_drain();
                queue_random_run(PHASE_BEATS / 2);
            end
            else
                queue_random_run(PHASE_BEATS);
        end

        // hold reset, then release it on a falling edge
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;

        while (pending_ops.size() > 0 || in_valid || expected_slots.size() > 0)
            @(posedge clk);
        repeat (END_WAIT) @(posedge clk);

        if (fail_count == 0 && expected_slots.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

`default_nettype wire
